[hw/rtl/hsc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers for the HSV/HSL to RGB converter.
// No dependencies; used by every stage module and by the top level.
package hsc_pkg;

    // Default hue width in bits
    localparam int HSC_HUE_BITS = 12;

    // Configuration port
    localparam int HSC_CFG_IDX_BITS  = 1;
    localparam int HSC_CFG_DATA_BITS = 8;

    typedef logic [HSC_CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [HSC_CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [7:0]                   t_byte;

    localparam t_cfg_idx CFG_CONV_MODE = 1'b0;
    localparam t_cfg_idx CFG_LEVEL     = 1'b1;

    // Conversion mode codes
    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_HSL = 1'b1;

    // HSV hue sectors, in order around the wheel
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    // floor(x / 255) for x below 2^16, clamped to a byte
    function automatic t_byte div255_sat(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        if (sum[16]) begin
            return 8'd255;
        end
        return sum[15:8];
    endfunction

endpackage

[hw/rtl/hsc_front.sv]
`timescale 1ns / 1ps
// First pipeline stage: hue sector and fraction, HSV partial terms,
// HSL levels and per-channel ramp weights. Depends on hsc_pkg.
module hsc_front #(
    parameter int HUE_BITS = hsc_pkg::HSC_HUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_mode,
    input  hsc_pkg::t_byte      i_level,
    input  logic [HUE_BITS-1:0] i_hue,
    input  hsc_pkg::t_byte      i_sat,
    output logic                o_mode,
    output hsc_pkg::t_sector    o_sec,
    output hsc_pkg::t_byte      o_level,
    output logic [HUE_BITS+7:0] o_sf,
    output logic [HUE_BITS+7:0] o_snf,
    output logic [15:0]         o_py,
    output logic [15:0]         o_t2,
    output logic [15:0]         o_d,
    output logic [HUE_BITS:0]   o_kr,
    output logic [HUE_BITS:0]   o_kg,
    output logic [HUE_BITS:0]   o_kb
);
    import hsc_pkg::*;

    localparam int HB = HUE_BITS;
    localparam logic [HB:0]   FULL  = {1'b1, {HB{1'b0}}};
    localparam logic [HB+2:0] N_X   = (HB+3)'(1) << HB;
    localparam logic [HB+2:0] N2_X  = (HB+3)'(2) << HB;
    localparam logic [HB+2:0] N3_X  = (HB+3)'(3) << HB;
    localparam logic [HB+2:0] N4_X  = (HB+3)'(4) << HB;

    // Ramp weight k in units of 1/N for a hue a3 given in units of 1/(3N)
    function automatic logic [HB:0] ramp_k(input logic [HB+2:0] a3);
        logic [HB+2:0] a2;
        logic [HB+2:0] fall;
        a2   = {a3[HB+1:0], 1'b0};
        fall = N4_X - a2;
        if (a2 < N_X) begin
            return a2[HB:0];
        end else if (a2 < N3_X) begin
            return FULL;
        end else if (a3 < N2_X) begin
            return fall[HB:0];
        end
        return '0;
    endfunction

    logic [HB+2:0] w_six;
    logic [HB-1:0] w_f;
    logic [HB:0]   w_nf;
    logic [HB+7:0] w_sf;
    logic [HB+7:0] w_snf;
    logic [15:0]   w_py;
    logic [16:0]   w_t1;
    logic [16:0]   w_t2;
    logic [16:0]   w_d;
    logic [15:0]   w_ls;
    logic [HB+2:0] w_h3;
    logic [HB+2:0] w_ar;
    logic [HB+2:0] w_ab;

    logic             r_mode;
    t_sector          r_sec;
    t_byte            r_level;
    logic [HB+7:0]    r_sf;
    logic [HB+7:0]    r_snf;
    logic [15:0]      r_py;
    logic [15:0]      r_t2;
    logic [15:0]      r_d;
    logic [HB:0]      r_kr;
    logic [HB:0]      r_kg;
    logic [HB:0]      r_kb;

    always_comb begin
        // 6h split into sector and fraction
        w_six = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};
        w_f   = w_six[HB-1:0];
        w_nf  = FULL - {1'b0, w_f};
        w_sf  = {{HB{1'b0}}, i_sat} * {8'd0, w_f};
        w_snf = {{HB{1'b0}}, i_sat} * {7'd0, w_nf};
        w_py  = {8'd0, i_level} * {8'd0, 8'd255 - i_sat};

        // HSL levels scaled by 255*255
        w_ls = {8'd0, i_level} * {8'd0, i_sat};
        if (!i_level[7]) begin
            w_t1 = {9'd0, i_level} * (17'd255 + {9'd0, i_sat});
        end else begin
            w_t1 = ({9'd0, i_level} + {9'd0, i_sat}) * 17'd255 - {1'b0, w_ls};
        end
        w_t2 = {9'd0, i_level} * 17'd510 - w_t1;
        w_d  = w_t1 - w_t2;

        // channel hues offset by a third of a turn, wrapped
        w_h3 = {2'b00, i_hue, 1'b0} + {3'b000, i_hue};
        w_ar = w_h3 + N_X;
        if (w_ar >= N3_X) begin
            w_ar = w_ar - N3_X;
        end
        w_ab = w_h3 + N2_X;
        if (w_ab >= N3_X) begin
            w_ab = w_ab - N3_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode  <= i_mode;
            r_sec   <= t_sector'(w_six[HB+2:HB]);
            r_level <= i_level;
            r_sf    <= w_sf;
            r_snf   <= w_snf;
            r_py    <= w_py;
            r_t2    <= w_t2[15:0];
            r_d     <= w_d[15:0];
            r_kr    <= ramp_k(w_ar);
            r_kg    <= ramp_k(w_h3);
            r_kb    <= ramp_k(w_ab);
        end
    end

    assign o_mode  = r_mode;
    assign o_sec   = r_sec;
    assign o_level = r_level;
    assign o_sf    = r_sf;
    assign o_snf   = r_snf;
    assign o_py    = r_py;
    assign o_t2    = r_t2;
    assign o_d     = r_d;
    assign o_kr    = r_kr;
    assign o_kg    = r_kg;
    assign o_kb    = r_kb;

endmodule

[hw/rtl/hsc_mult.sv]
`timescale 1ns / 1ps
// Second pipeline stage: the level multiplications for the HSV q and t
// terms and the ramp products for HSL. Depends on hsc_pkg.
module hsc_mult #(
    parameter int HUE_BITS = hsc_pkg::HSC_HUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_mode,
    input  hsc_pkg::t_sector    i_sec,
    input  hsc_pkg::t_byte      i_level,
    input  logic [HUE_BITS+7:0] i_sf,
    input  logic [HUE_BITS+7:0] i_snf,
    input  logic [15:0]         i_py,
    input  logic [15:0]         i_t2,
    input  logic [15:0]         i_d,
    input  logic [HUE_BITS:0]   i_kr,
    input  logic [HUE_BITS:0]   i_kg,
    input  logic [HUE_BITS:0]   i_kb,
    output logic                o_mode,
    output hsc_pkg::t_sector    o_sec,
    output hsc_pkg::t_byte      o_level,
    output logic [15:0]         o_py,
    output logic [15:0]         o_yq,
    output logic [15:0]         o_yt,
    output logic [15:0]         o_t2,
    output logic [15:0]         o_kdr,
    output logic [15:0]         o_kdg,
    output logic [15:0]         o_kdb
);
    import hsc_pkg::*;

    localparam int HB = HUE_BITS;
    localparam logic [HB+7:0] DEN = (HB+8)'(255) << HB;

    logic [HB+15:0] w_xq;
    logic [HB+15:0] w_xt;
    logic [HB+16:0] w_kdr;
    logic [HB+16:0] w_kdg;
    logic [HB+16:0] w_kdb;

    logic           r_mode;
    t_sector        r_sec;
    t_byte          r_level;
    logic [15:0]    r_py;
    logic [15:0]    r_yq;
    logic [15:0]    r_yt;
    logic [15:0]    r_t2;
    logic [15:0]    r_kdr;
    logic [15:0]    r_kdg;
    logic [15:0]    r_kdb;

    always_comb begin
        w_xq  = {{(HB+8){1'b0}}, i_level} * {8'd0, DEN - i_sf};
        w_xt  = {{(HB+8){1'b0}}, i_level} * {8'd0, DEN - i_snf};
        w_kdr = {16'd0, i_kr} * {{(HB+1){1'b0}}, i_d};
        w_kdg = {16'd0, i_kg} * {{(HB+1){1'b0}}, i_d};
        w_kdb = {16'd0, i_kb} * {{(HB+1){1'b0}}, i_d};
    end

    // drop the 1/N scale here; the /255 follows in the last stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode  <= i_mode;
            r_sec   <= i_sec;
            r_level <= i_level;
            r_py    <= i_py;
            r_yq    <= w_xq[HB+15:HB];
            r_yt    <= w_xt[HB+15:HB];
            r_t2    <= i_t2;
            r_kdr   <= w_kdr[HB+15:HB];
            r_kdg   <= w_kdg[HB+15:HB];
            r_kdb   <= w_kdb[HB+15:HB];
        end
    end

    assign o_mode  = r_mode;
    assign o_sec   = r_sec;
    assign o_level = r_level;
    assign o_py    = r_py;
    assign o_yq    = r_yq;
    assign o_yt    = r_yt;
    assign o_t2    = r_t2;
    assign o_kdr   = r_kdr;
    assign o_kdg   = r_kdg;
    assign o_kdb   = r_kdb;

endmodule

[hw/rtl/hsc_back.sv]
`timescale 1ns / 1ps
// Last pipeline stage: divide by 255, clamp, pick channels by sector or
// mode, and hold the result in the output register. Depends on hsc_pkg.
module hsc_back (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_mode,
    input  hsc_pkg::t_sector i_sec,
    input  hsc_pkg::t_byte   i_level,
    input  logic [15:0]      i_py,
    input  logic [15:0]      i_yq,
    input  logic [15:0]      i_yt,
    input  logic [15:0]      i_t2,
    input  logic [15:0]      i_kdr,
    input  logic [15:0]      i_kdg,
    input  logic [15:0]      i_kdb,
    output hsc_pkg::t_byte   o_red,
    output hsc_pkg::t_byte   o_green,
    output hsc_pkg::t_byte   o_blue
);
    import hsc_pkg::*;

    logic [16:0] w_yr;
    logic [16:0] w_yg;
    logic [16:0] w_yb;
    logic [15:0] w_a;
    logic [15:0] w_b;
    logic [15:0] w_c;
    t_byte       w_da;
    t_byte       w_db;
    t_byte       w_dc;
    t_byte       w_red;
    t_byte       w_green;
    t_byte       w_blue;

    t_byte       r_red;
    t_byte       r_green;
    t_byte       r_blue;

    always_comb begin
        w_yr = {1'b0, i_t2} + {1'b0, i_kdr};
        w_yg = {1'b0, i_t2} + {1'b0, i_kdg};
        w_yb = {1'b0, i_t2} + {1'b0, i_kdb};

        // share the three dividers between the modes
        if (i_mode == MODE_HSL) begin
            w_a = w_yr[15:0];
            w_b = w_yg[15:0];
            w_c = w_yb[15:0];
        end else begin
            w_a = i_py;
            w_b = i_yq;
            w_c = i_yt;
        end
        w_da = div255_sat(w_a);
        w_db = div255_sat(w_b);
        w_dc = div255_sat(w_c);

        if (i_mode == MODE_HSL) begin
            w_red   = w_da;
            w_green = w_db;
            w_blue  = w_dc;
        end else begin
            // w_da is p, w_db is q, w_dc is t
            case (i_sec)
                SEC_RY: begin
                    w_red = i_level; w_green = w_dc;    w_blue = w_da;
                end
                SEC_YG: begin
                    w_red = w_db;    w_green = i_level; w_blue = w_da;
                end
                SEC_GC: begin
                    w_red = w_da;    w_green = i_level; w_blue = w_dc;
                end
                SEC_CB: begin
                    w_red = w_da;    w_green = w_db;    w_blue = i_level;
                end
                SEC_BM: begin
                    w_red = w_dc;    w_green = w_da;    w_blue = i_level;
                end
                default: begin
                    w_red = i_level; w_green = w_da;    w_blue = w_db;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= w_red;
            r_green <= w_green;
            r_blue  <= w_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

[hw/rtl/hsv_hsl_to_rgb_pixel_converter.sv]
`timescale 1ns / 1ps
// HSV/HSL to RGB pixel converter, top level. Three register stages:
// a request passes the front, mult and back registers in turn, and one request is
// taken every cycle while the output side keeps stall low.
// Throughput is set by the pipeline; the three-stage valid chain absorbs stalls.
// Synchronous active-low reset clears the valid bits, mode (HSV) and level.
// Depends on hsc_pkg, hsc_front, hsc_mult and hsc_back.
module hsv_hsl_to_rgb_pixel_converter #(
    parameter int HUE_BITS = hsc_pkg::HSC_HUE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  hsc_pkg::t_cfg_idx    i_cfg_idx,
    input  hsc_pkg::t_cfg_data   i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [HUE_BITS-1:0]  i_hue,
    input  hsc_pkg::t_byte       i_saturation,
    output logic                 o_valid,
    input  logic                 i_stall,
    output hsc_pkg::t_byte       o_red,
    output hsc_pkg::t_byte       o_green,
    output hsc_pkg::t_byte       o_blue
);
    import hsc_pkg::*;

    localparam int HB = HUE_BITS;

    logic        r_conv_mode;
    t_byte       r_level;
    logic [2:0]  r_vld;

    logic        w_rdy1;
    logic        w_rdy2;
    logic        w_rdy3;
    logic        w_en1;
    logic        w_en2;
    logic        w_en3;

    logic          s1_mode;
    t_sector       s1_sec;
    t_byte         s1_level;
    logic [HB+7:0] s1_sf;
    logic [HB+7:0] s1_snf;
    logic [15:0]   s1_py;
    logic [15:0]   s1_t2;
    logic [15:0]   s1_d;
    logic [HB:0]   s1_kr;
    logic [HB:0]   s1_kg;
    logic [HB:0]   s1_kb;

    logic          s2_mode;
    t_sector       s2_sec;
    t_byte         s2_level;
    logic [15:0]   s2_py;
    logic [15:0]   s2_yq;
    logic [15:0]   s2_yt;
    logic [15:0]   s2_t2;
    logic [15:0]   s2_kdr;
    logic [15:0]   s2_kdg;
    logic [15:0]   s2_kdb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_mode <= MODE_HSV;
            r_level     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONV_MODE: r_conv_mode <= i_cfg_data[0];
                CFG_LEVEL:     r_level     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or the stage after it moves
    assign w_rdy3  = !r_vld[2] || !i_stall;
    assign w_rdy2  = !r_vld[1] || w_rdy3;
    assign w_rdy1  = !r_vld[0] || w_rdy2;
    assign w_en1   = i_valid && w_rdy1;
    assign w_en2   = r_vld[0] && w_rdy2;
    assign w_en3   = r_vld[1] && w_rdy3;
    assign o_stall = !w_rdy1;
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy1) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy2) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy3) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    hsc_front #(
        .HUE_BITS (HUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_en    (w_en1),
        .i_mode  (r_conv_mode),
        .i_level (r_level),
        .i_hue   (i_hue),
        .i_sat   (i_saturation),
        .o_mode  (s1_mode),
        .o_sec   (s1_sec),
        .o_level (s1_level),
        .o_sf    (s1_sf),
        .o_snf   (s1_snf),
        .o_py    (s1_py),
        .o_t2    (s1_t2),
        .o_d     (s1_d),
        .o_kr    (s1_kr),
        .o_kg    (s1_kg),
        .o_kb    (s1_kb)
    );

    hsc_mult #(
        .HUE_BITS (HUE_BITS)
    ) u_mult (
        .i_clk   (i_clk),
        .i_en    (w_en2),
        .i_mode  (s1_mode),
        .i_sec   (s1_sec),
        .i_level (s1_level),
        .i_sf    (s1_sf),
        .i_snf   (s1_snf),
        .i_py    (s1_py),
        .i_t2    (s1_t2),
        .i_d     (s1_d),
        .i_kr    (s1_kr),
        .i_kg    (s1_kg),
        .i_kb    (s1_kb),
        .o_mode  (s2_mode),
        .o_sec   (s2_sec),
        .o_level (s2_level),
        .o_py    (s2_py),
        .o_yq    (s2_yq),
        .o_yt    (s2_yt),
        .o_t2    (s2_t2),
        .o_kdr   (s2_kdr),
        .o_kdg   (s2_kdg),
        .o_kdb   (s2_kdb)
    );

    hsc_back u_back (
        .i_clk   (i_clk),
        .i_en    (w_en3),
        .i_mode  (s2_mode),
        .i_sec   (s2_sec),
        .i_level (s2_level),
        .i_py    (s2_py),
        .i_yq    (s2_yq),
        .i_yt    (s2_yt),
        .i_t2    (s2_t2),
        .i_kdr   (s2_kdr),
        .i_kdg   (s2_kdg),
        .i_kdb   (s2_kdb),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

[tb/hsv_hsl_to_rgb_pixel_converter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the HSV/HSL to RGB pixel converter.
// Depends on hsc_pkg and hsv_hsl_to_rgb_pixel_converter, and through it on the stage modules.
module hsv_hsl_to_rgb_pixel_converter_tb;
    import hsc_pkg::*;

    localparam int          HUE_BITS       = HSC_HUE_BITS;
    localparam int          HUE_MAX        = (1 << HUE_BITS) - 1;
    localparam logic [63:0] HUE_N          = 64'd1 << HUE_BITS;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_PHASES  = 12;
    localparam int          PHASE_PIXELS   = 100;

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
    } t_rgb;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    t_cfg_idx            i_cfg_idx    = CFG_CONV_MODE;
    t_cfg_data           i_cfg_data   = '0;
    logic                i_valid      = 1'b0;
    logic [HUE_BITS-1:0] i_hue        = '0;
    t_byte               i_saturation = '0;
    logic                i_stall      = 1'b0;
    logic                o_stall;
    logic                o_valid;
    t_byte               o_red;
    t_byte               o_green;
    t_byte               o_blue;

    // Shadow copy of the block's registers
    logic  mode_reg  = MODE_HSV;
    t_byte level_reg = '0;

    t_rgb  pending_rgb[$];
    int    mismatches     = 0;
    int    pixels_sent    = 0;
    int    pixels_checked = 0;
    int    burst_left     = 0;
    int    idle_cycles    = 0;
    logic  steady         = 1'b0;
    logic [15:0] stall_bits  = '0;
    logic [3:0]  stall_phase = '0;

    hsv_hsl_to_rgb_pixel_converter #(
        .HUE_BITS(HUE_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_hue(i_hue),
        .i_saturation(i_saturation),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_byte clamp_byte(input logic [63:0] x);
        return (x > 64'd255) ? 8'd255 : x[7:0];
    endfunction

    // One HSL channel; a3 is the hue in thirds of a hue step, hi and lo scaled by 255^2
    function automatic t_byte hsl_channel(input logic [63:0] a3, input logic [63:0] hi,
                                          input logic [63:0] lo);
        logic [63:0] k;
        if (2 * a3 < HUE_N) begin
            k = 2 * a3;
        end else if (2 * a3 < 3 * HUE_N) begin
            k = HUE_N;
        end else if (a3 < 2 * HUE_N) begin
            k = 4 * HUE_N - 2 * a3;
        end else begin
            k = 0;
        end
        return clamp_byte((lo * HUE_N + k * (hi - lo)) / (255 * HUE_N));
    endfunction

    function automatic t_rgb hsx_to_rgb(input logic mode, input t_byte lvl,
                                        input logic [HUE_BITS-1:0] hue, input t_byte sat);
        logic [63:0] h, s, l, six, sidx, f, den, hi, lo;
        t_byte       vb, pb, qb, tb;
        t_sector     sec;
        t_rgb        rgb;
        h = 64'(hue);
        s = 64'(sat);
        l = 64'(lvl);
        if (mode == MODE_HSV) begin
            six  = 6 * h;
            sidx = six / HUE_N;
            f    = six - sidx * HUE_N;
            den  = 255 * HUE_N;
            sec  = t_sector'(sidx[2:0]);
            vb   = lvl;
            pb   = clamp_byte(l * (255 - s) / 255);
            qb   = clamp_byte(l * (den - s * f) / den);
            tb   = clamp_byte(l * (den - s * (HUE_N - f)) / den);
            case (sec)
                SEC_RY: rgb = '{vb, tb, pb};
                SEC_YG: rgb = '{qb, vb, pb};
                SEC_GC: rgb = '{pb, vb, tb};
                SEC_CB: rgb = '{pb, qb, vb};
                SEC_BM: rgb = '{tb, pb, vb};
                default: rgb = '{vb, pb, qb};
            endcase
        end else begin
            if (2 * l < 255) begin
                hi = l * (255 + s);
            end else begin
                hi = 255 * l + 255 * s - l * s;
            end
            lo = 510 * l - hi;
            rgb.red   = hsl_channel((3 * h + HUE_N) % (3 * HUE_N), hi, lo);
            rgb.green = hsl_channel(3 * h, hi, lo);
            rgb.blue  = hsl_channel((3 * h + 2 * HUE_N) % (3 * HUE_N), hi, lo);
        end
        return rgb;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CONV_MODE: mode_reg = data[0];
            default: level_reg = data;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [HUE_BITS-1:0] hue, input t_byte sat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        do @(posedge i_clk); while (o_stall);
        pending_rgb.push_back(hsx_to_rgb(mode_reg, level_reg, hue, sat));
        pixels_sent++;
    endtask

    // Hold off new requests until every expected pixel is back
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        // Level resets to zero, so every pixel is black
        send_pixel('0, 8'd255);
        send_pixel(HUE_BITS'(2048), 8'd128);
        drain();
    endtask

    task automatic test_hsv_corners();
        // Upper bits of the mode write are ignored
        write_reg(CFG_CONV_MODE, 8'hFE);
        write_reg(CFG_LEVEL, 8'd255);
        send_pixel('0, 8'd255);
        send_pixel(HUE_BITS'(682), 8'd255);
        send_pixel(HUE_BITS'(683), 8'd255);
        send_pixel(HUE_BITS'(1365), 8'd255);
        send_pixel(HUE_BITS'(1366), 8'd255);
        send_pixel(HUE_BITS'(2048), 8'd255);
        send_pixel(HUE_BITS'(2731), 8'd255);
        send_pixel(HUE_BITS'(3413), 8'd255);
        send_pixel(HUE_BITS'(3414), 8'd255);
        send_pixel(HUE_BITS'(HUE_MAX), 8'd255);
        send_pixel(HUE_BITS'(1000), 8'd0);
        send_pixel(HUE_BITS'(3000), 8'd128);
        drain();
    endtask

    task automatic test_hsl_corners();
        write_reg(CFG_CONV_MODE, 8'hFF);
        write_reg(CFG_LEVEL, 8'd127);
        send_pixel('0, 8'd255);
        send_pixel(HUE_BITS'(1365), 8'd255);
        send_pixel(HUE_BITS'(2731), 8'd255);
        send_pixel(HUE_BITS'(HUE_MAX), 8'd255);
        send_pixel(HUE_BITS'(700), 8'd0);
        drain();
        write_reg(CFG_LEVEL, 8'd128);
        send_pixel(HUE_BITS'(683), 8'd255);
        send_pixel(HUE_BITS'(2048), 8'd255);
        send_pixel(HUE_BITS'(3414), 8'd255);
        send_pixel(HUE_BITS'(100), 8'd0);
        drain();
        write_reg(CFG_LEVEL, 8'd0);
        send_pixel(HUE_BITS'(1234), 8'd255);
        drain();
        write_reg(CFG_LEVEL, 8'd255);
        send_pixel(HUE_BITS'(2222), 8'd255);
        drain();
    endtask

    task automatic test_random_pixels();
        t_byte       phase_levels[5] = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1};
        t_cfg_data   mode_word;
        logic [31:0] rnd;
        logic [HUE_BITS-1:0] hue;
        t_byte       sat;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            rnd = $urandom;
            mode_word    = rnd[7:0];
            mode_word[0] = (p % 2 == 1) ? MODE_HSL : MODE_HSV;
            write_reg(CFG_CONV_MODE, mode_word);
            rnd = $urandom;
            write_reg(CFG_LEVEL, (p < 10) ? phase_levels[p / 2] : rnd[7:0]);
            steady = (p % 4 == 3);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                rnd = $urandom;
                hue = rnd[HUE_BITS-1:0];
                sat = rnd[23:16];
                case (rnd[31:28])
                    4'd0: hue = '0;
                    4'd1: hue = HUE_BITS'(HUE_MAX);
                    4'd2: sat = 8'd0;
                    4'd3: sat = 8'd255;
                    default: ;
                endcase
                send_pixel(hue, sat);
                if (p == 2 && n == PHASE_PIXELS / 2) begin
                    drain();
                end
            end
            drain();
        end
        steady = 1'b0;
    endtask

    // Output side: stall on the bits of stall_bits in turn, reshuffled each time the phase wraps
    always @(posedge i_clk) begin
        logic [31:0] a, b;
        if (!i_rst_n || steady) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_phase == 4'd0) begin
                a = $urandom;
                b = $urandom;
                case (a[31:30])
                    2'd0: stall_bits = '0;
                    2'd1: stall_bits = a[15:0];
                    2'd2: stall_bits = a[15:0] & b[15:0];
                    default: stall_bits = a[15:0] | b[15:0];
                endcase
            end
            i_stall     <= stall_bits[stall_phase];
            stall_phase <= stall_phase + 4'd1;
        end
    end

    always @(posedge i_clk) begin
        t_rgb exp_rgb;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_rgb.size() == 0) begin
                $error("pixel out with none pending: r=%0d g=%0d b=%0d", o_red, o_green,
                       o_blue);
                mismatches++;
            end else begin
                exp_rgb = pending_rgb.pop_front();
                pixels_checked++;
                if (o_red !== exp_rgb.red) begin
                    $error("red: expected %0d, got %0d", exp_rgb.red, o_red);
                    mismatches++;
                end
                if (o_green !== exp_rgb.green) begin
                    $error("green: expected %0d, got %0d", exp_rgb.green, o_green);
                    mismatches++;
                end
                if (o_blue !== exp_rgb.blue) begin
                    $error("blue: expected %0d, got %0d", exp_rgb.blue, o_blue);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles with no transfer", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_hsv_corners();
        test_hsl_corners();
        test_random_pixels();
        // Allow for a stray pixel behind the three-stage pipeline
        repeat (8) @(posedge i_clk);
        if (pending_rgb.size() != 0) begin
            $error("%0d pixels never came out", pending_rgb.size());
            mismatches++;
        end
        $display("Checked %0d of %0d pixels in HSV and HSL over levels 0, 1, 127, 128, 255",
                 pixels_checked, pixels_sent);
        $display("and random ones, with bursty input and patterned output stalls.");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[hsv_hsl_to_rgb_pixel_converter.f]
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_front.sv
hw/rtl/hsc_mult.sv
hw/rtl/hsc_back.sv
hw/rtl/hsv_hsl_to_rgb_pixel_converter.sv
tb/hsv_hsl_to_rgb_pixel_converter_tb.sv
